[rtl/core/lis_pkg.sv]
// lis_pkg: shared constants, state enum, command/status structs and store entry
// type for the longest increasing subsequence core. No dependencies.
package lis_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;                        // lis_value / value field width
  localparam int LEN_OUT_W = 7;                         // lis_length field width
  localparam int LEN_W     = $clog2(MAX_ITEMS + 1);     // counts 0..MAX_ITEMS
  localparam int IDX_W     = $clog2(MAX_ITEMS);         // store address

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_STORE,
    ST_TRACE_INIT,
    ST_TRACE_RD,
    ST_TRACE_WR,
    ST_EMIT_RD,
    ST_EMIT_LD
  } lis_state_t;

  typedef struct packed {
    logic accept;      // latch incoming request, start scan
    logic scan;        // one scan step over the store
    logic store;       // write new entry, update best run
    logic trace_init;  // load trace pointers from best run
    logic trace_sel;   // store read address from trace pointer
    logic trace_step;  // copy one run element to output buffer
    logic emit_load;   // move one element to output register
  } lis_cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic scan_done;
    logic trace_done;
    logic emit_done;
    logic out_free;
  } lis_status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [LEN_W-1:0]         len;
    logic [IDX_W-1:0]         pred;
  } lis_entry_t;

endpackage

[rtl/core/lis_in_if.sv]
// lis_in_if: input request channel (valid/ready, value, last_item).
// Depends on lis_pkg.
interface lis_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [lis_pkg::DATA_W-1:0] value;
  logic                             last_item;

  modport source(output valid, output value, output last_item, input ready);
  modport sink(input valid, input value, input last_item, output ready);
endinterface

[rtl/core/lis_out_if.sv]
// lis_out_if: result channel (valid/ready, lis_value, lis_length, overflow, last_result).
// Depends on lis_pkg.
interface lis_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lis_pkg::DATA_W-1:0]    lis_value;
  logic [lis_pkg::LEN_OUT_W-1:0]        lis_length;
  logic                                overflow;
  logic                                last_result;

  modport source(output valid, output lis_value, output lis_length, output overflow,
                 output last_result, input ready);
  modport sink(input valid, input lis_value, input lis_length, input overflow,
               input last_result, output ready);
endinterface

[rtl/core/lis_ctrl.sv]
// lis_ctrl: sequencing state machine; issues commands to lis_datapath from its status.
// Depends on lis_pkg.
module lis_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lis_pkg::lis_status_t status,
  output lis_pkg::lis_cmd_t    cmd
);

  lis_pkg::lis_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lis_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      lis_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = lis_pkg::ST_DECIDE;
        end
      end
      lis_pkg::ST_DECIDE: begin
        // full store drops the request, but its last mark still closes
        if (status.full) begin
          state_nxt = status.last ? lis_pkg::ST_TRACE_INIT : lis_pkg::ST_IDLE;
        end else begin
          state_nxt = lis_pkg::ST_SCAN;
        end
      end
      lis_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = lis_pkg::ST_STORE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      lis_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = status.last ? lis_pkg::ST_TRACE_INIT : lis_pkg::ST_IDLE;
      end
      lis_pkg::ST_TRACE_INIT: begin
        cmd.trace_init = 1'b1;
        state_nxt      = lis_pkg::ST_TRACE_RD;
      end
      lis_pkg::ST_TRACE_RD: begin
        cmd.trace_sel = 1'b1;
        state_nxt     = lis_pkg::ST_TRACE_WR;
      end
      lis_pkg::ST_TRACE_WR: begin
        cmd.trace_sel  = 1'b1;
        cmd.trace_step = 1'b1;
        state_nxt      = status.trace_done ? lis_pkg::ST_EMIT_RD : lis_pkg::ST_TRACE_RD;
      end
      lis_pkg::ST_EMIT_RD: begin
        state_nxt = lis_pkg::ST_EMIT_LD;
      end
      lis_pkg::ST_EMIT_LD: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = status.emit_done ? lis_pkg::ST_IDLE : lis_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = lis_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/lis_datapath.sv]
// lis_datapath: entry store, scan compare, trace pointer, output buffer and output
// register. Driven by lis_ctrl commands. Depends on lis_pkg.
module lis_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lis_pkg::lis_cmd_t                   cmd,
  output lis_pkg::lis_status_t                status,
  input  logic signed [lis_pkg::DATA_W-1:0]   in_value,
  input  logic                                in_last_item,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [lis_pkg::DATA_W-1:0]   out_lis_value,
  output logic [lis_pkg::LEN_OUT_W-1:0]       out_lis_length,
  output logic                                out_overflow,
  output logic                                out_last_result
);

  localparam int LW = lis_pkg::LEN_W;
  localparam int IW = lis_pkg::IDX_W;

  // request latch and scan accumulators (payload)
  logic signed [lis_pkg::DATA_W-1:0] val_r;
  logic                              last_r;
  logic [LW-1:0]                     len_r;
  logic [IW-1:0]                     pred_r;

  // control
  logic [LW-1:0] cnt_r;
  logic [LW-1:0] best_len_r;
  logic [IW-1:0] best_end_r;
  logic          ovf_r;
  logic [LW-1:0] j_r;
  logic          pend_r;
  logic [LW-1:0] k_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] e_r;
  logic          out_valid_r;

  // output register payload
  logic signed [lis_pkg::DATA_W-1:0] out_value_r;
  logic [lis_pkg::LEN_OUT_W-1:0]     out_length_r;
  logic                              out_ovf_r;
  logic                              out_last_r;

  // memories
  lis_pkg::lis_entry_t               store_mem [lis_pkg::MAX_ITEMS];
  lis_pkg::lis_entry_t               rdata_r;
  logic signed [lis_pkg::DATA_W-1:0] obuf_mem [lis_pkg::MAX_ITEMS];
  logic signed [lis_pkg::DATA_W-1:0] obuf_rdata_r;

  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] k_slot;
  logic          hit;
  logic          emit_final;
  logic [LW-1:0] k_dec;

  assign rd_addr    = cmd.trace_sel ? idx_r : j_r[IW-1:0];
  assign wr_addr    = cnt_r[IW-1:0];
  assign k_dec      = k_r - LW'(1);
  assign k_slot     = k_dec[IW-1:0];
  // strictly smaller value whose run would beat the current one; strict > keeps earliest
  assign hit        = pend_r && ($signed(rdata_r.value) < $signed(val_r)) &&
                      (rdata_r.len >= len_r);
  assign emit_final = ({1'b0, e_r} == (best_len_r - LW'(1)));

  assign status.full       = (cnt_r == LW'(lis_pkg::MAX_ITEMS));
  assign status.last       = last_r;
  assign status.scan_done  = (j_r == cnt_r) && !pend_r;
  assign status.trace_done = (k_r == LW'(1));
  assign status.emit_done  = emit_final;
  assign status.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      store_mem[wr_addr] <= '{value: val_r, len: len_r, pred: pred_r};
    end
    rdata_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.trace_step) begin
      obuf_mem[k_slot] <= rdata_r.value;
    end
    obuf_rdata_r <= obuf_mem[e_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      best_len_r  <= '0;
      best_end_r  <= '0;
      ovf_r       <= 1'b0;
      j_r         <= '0;
      pend_r      <= 1'b0;
      k_r         <= '0;
      idx_r       <= '0;
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        j_r    <= '0;
        pend_r <= 1'b0;
        if (status.full) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.scan) begin
        if (j_r < cnt_r) begin
          j_r    <= j_r + LW'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
      end
      if (cmd.store) begin
        cnt_r <= cnt_r + LW'(1);
        if (len_r > best_len_r) begin
          best_len_r <= len_r;
          best_end_r <= wr_addr;
        end
      end
      if (cmd.trace_init) begin
        k_r   <= best_len_r;
        idx_r <= best_end_r;
        e_r   <= '0;
      end
      if (cmd.trace_step) begin
        k_r   <= k_dec;
        idx_r <= rdata_r.pred;
      end
      if (cmd.emit_load) begin
        if (emit_final) begin
          cnt_r      <= '0;
          best_len_r <= '0;
          best_end_r <= '0;
          ovf_r      <= 1'b0;
        end else begin
          e_r <= e_r + IW'(1);
        end
      end
      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r  <= in_value;
      last_r <= in_last_item;
      len_r  <= LW'(1);
      pred_r <= wr_addr;
    end else if (cmd.scan && hit) begin
      len_r  <= rdata_r.len + LW'(1);
      pred_r <= j_r[IW-1:0] - IW'(1);   // j_r already points one past the data
    end
    if (cmd.emit_load) begin
      out_value_r  <= obuf_rdata_r;
      out_length_r <= lis_pkg::LEN_OUT_W'(best_len_r);
      out_ovf_r    <= ovf_r;
      out_last_r   <= emit_final;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lis_value   = out_value_r;
  assign out_lis_length  = out_length_r;
  assign out_overflow    = out_ovf_r;
  assign out_last_result = out_last_r;

endmodule

[rtl/core/longest_increasing_subsequence_core.sv]
// Longest strictly increasing subsequence core, quadratic DP over a 64-entry store.
// Each request is accepted, decided, scans the stored entries with one store read per
// cycle and is stored; into a full store it is dropped after decide. On the last
// request: trace init, a read and a write step per run element, then a read and a
// load step per result, each load waiting for a free output. Reset (rst_n, sync,
// active low) clears control registers; entry and output buffers are never cleared.
module longest_increasing_subsequence_core (
  input  logic             clk,
  input  logic             rst_n,
  lis_in_if.sink           in_ch,
  lis_out_if.source        out_ch
);

  lis_pkg::lis_cmd_t    cmd;
  lis_pkg::lis_status_t status;
  logic                 in_ready;

  lis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lis_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_value        (in_ch.value),
    .in_last_item    (in_ch.last_item),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_lis_value   (out_ch.lis_value),
    .out_lis_length  (out_ch.lis_length),
    .out_overflow    (out_ch.overflow),
    .out_last_result (out_ch.last_result)
  );

  assign in_ch.ready = in_ready;

endmodule
